// File: src/pngu_pkg.sv
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared types and codes of the PNG scanline unfilter.
// ----------------------------------------------------------------------------
package pngu_pkg;

   // filter type codes carried in the first byte of each row
   localparam logic [7:0] FILTER_NONE  = 8'd0;
   localparam logic [7:0] FILTER_SUB   = 8'd1;
   localparam logic [7:0] FILTER_UP    = 8'd2;
   localparam logic [7:0] FILTER_AVG   = 8'd3;
   localparam logic [7:0] FILTER_PAETH = 8'd4;

   // register indexes of the write port
   localparam logic CSR_BYTES_PER_PIXEL = 1'b0;
   localparam logic CSR_PIXELS_PER_ROW  = 1'b1;

   localparam int CSR_DATA_W = 14;

   // one accepted stream byte, classified by the sequencer
   typedef struct packed {
      logic       is_data;
      logic [7:0] data;
      logic [7:0] filter;
      logic       first_row;
      logic       row_end;
   } pngu_item_type;

endpackage

// File: src/pngu_if.sv
// ----------------------------------------------------------------------------
// pngu_req_if / pngu_rsp_if
// Valid/ready channels of the unfilter: stream bytes in, image bytes out.
// ----------------------------------------------------------------------------
interface pngu_req_if;
   logic       valid;
   logic       ready;
   logic       start_image;
   logic [7:0] stream_byte;

   modport source (output valid, output start_image, output stream_byte, input ready);
   modport sink   (input valid, input start_image, input stream_byte, output ready);
endinterface

interface pngu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   logic       row_end;

   modport source (output valid, output pixel_byte, output row_end, input ready);
   modport sink   (input valid, input pixel_byte, input row_end, output ready);
endinterface

// File: src/pngu_row_mem.sv
// ----------------------------------------------------------------------------
// pngu_row_mem
// Previous-row byte store, one write and one registered read port.
// ----------------------------------------------------------------------------
module pngu_row_mem #(
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pngu_seq.sv
// ----------------------------------------------------------------------------
// pngu_seq
// Row sequencer: registers, column count, filter byte tracking, row end.
// ----------------------------------------------------------------------------
module pngu_seq #(
   parameter int MAX_ROW_BYTES   = 8192,
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [pngu_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                accept,
   input  logic                                start_image,
   input  logic [7:0]                          stream_byte,
   output pngu_pkg::pngu_item_type             item,
   output logic [$clog2(MAX_ROW_BYTES)-1:0]    col,
   output logic [$clog2((MAX_PIXEL_BYTES > 1) ? MAX_PIXEL_BYTES : 2)-1:0] hist_idx
);

   localparam int COL_W      = $clog2(MAX_ROW_BYTES);
   localparam int PROD_W     = 18;
   localparam int HIST_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   logic [3:0]        bpp_ff;
   logic [13:0]       ppr_ff;
   logic [COL_W-1:0]  byte_column_ff, byte_column_in;
   logic              awaiting_ff, awaiting_in;
   logic              first_row_ff, first_row_in;
   logic [7:0]        row_filter_ff, row_filter_in;

   logic [3:0]        bpp_eff, bpp_m1;
   logic [13:0]       ppr_eff;
   logic [PROD_W-1:0] prod, row_len, col_nx;
   logic              awaiting_now, first_now, row_end;

   always_comb begin
      bpp_eff = bpp_ff;
      if (bpp_ff == 4'd0) begin
         bpp_eff = 4'd1;
      end else if (bpp_ff > 4'(MAX_PIXEL_BYTES)) begin
         bpp_eff = 4'(MAX_PIXEL_BYTES);
      end
      bpp_m1  = bpp_eff - 4'd1;
      ppr_eff = (ppr_ff == 14'd0) ? 14'd1 : ppr_ff;
      prod    = PROD_W'(ppr_eff) * PROD_W'(bpp_eff);
      row_len = (prod > PROD_W'(MAX_ROW_BYTES)) ? PROD_W'(MAX_ROW_BYTES) : prod;
   end

   assign hist_idx = bpp_m1[HIST_IDX_W-1:0];

   // a start mark drops the row in progress and opens a new image
   assign awaiting_now = start_image | awaiting_ff;
   assign first_now    = start_image | first_row_ff;
   assign col          = start_image ? '0 : byte_column_ff;
   assign col_nx       = PROD_W'(col) + PROD_W'(1);
   assign row_end      = !awaiting_now && (col_nx >= row_len);

   always_comb begin
      item.is_data   = !awaiting_now;
      item.data      = stream_byte;
      item.filter    = row_filter_ff;
      item.first_row = first_row_ff;
      item.row_end   = row_end;

      byte_column_in = byte_column_ff;
      awaiting_in    = awaiting_ff;
      first_row_in   = first_row_ff;
      row_filter_in  = row_filter_ff;
      if (accept) begin
         if (awaiting_now) begin
            row_filter_in  = stream_byte;
            awaiting_in    = 1'b0;
            byte_column_in = '0;
            first_row_in   = first_now;
         end else if (row_end) begin
            byte_column_in = '0;
            awaiting_in    = 1'b1;
            first_row_in   = 1'b0;
         end else begin
            byte_column_in = col_nx[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff         <= 4'd1;
         ppr_ff         <= 14'd1;
         byte_column_ff <= '0;
         awaiting_ff    <= 1'b1;
         first_row_ff   <= 1'b1;
         row_filter_ff  <= pngu_pkg::FILTER_NONE;
      end else begin
         byte_column_ff <= byte_column_in;
         awaiting_ff    <= awaiting_in;
         first_row_ff   <= first_row_in;
         row_filter_ff  <= row_filter_in;
         if (csr_we) begin
            unique case (csr_index)
               pngu_pkg::CSR_BYTES_PER_PIXEL: bpp_ff <= csr_wdata[3:0];
               pngu_pkg::CSR_PIXELS_PER_ROW:  ppr_ff <= csr_wdata[13:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// File: src/pngu_recon.sv
// ----------------------------------------------------------------------------
// pngu_recon
// Reconstruction stage: neighbor histories, filter arithmetic, result register.
// ----------------------------------------------------------------------------
module pngu_recon #(
   parameter int MAX_ROW_BYTES   = 8192,
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  pngu_pkg::pngu_item_type          item,
   input  logic [$clog2(MAX_ROW_BYTES)-1:0] col,
   input  logic [$clog2((MAX_PIXEL_BYTES > 1) ? MAX_PIXEL_BYTES : 2)-1:0] hist_idx,
   input  logic [7:0]                       up_byte,
   output logic                             in_ready,
   output logic                             wr_en,
   output logic [$clog2(MAX_ROW_BYTES)-1:0] wr_addr,
   output logic [7:0]                       wr_data,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [7:0]                       out_pixel,
   output logic                             out_row_end
);

   localparam int COL_W      = $clog2(MAX_ROW_BYTES);
   localparam int HIST_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [10:0] pa, pb, pc;
      pa = $signed({3'b000, b}) - $signed({3'b000, c});
      pb = $signed({3'b000, a}) - $signed({3'b000, c});
      pc = pa + pb;
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
   endfunction

   logic                      s1_valid_ff;
   pngu_pkg::pngu_item_type   s1_item_ff;
   logic [COL_W-1:0]          s1_col_ff;
   logic [HIST_IDX_W-1:0]     s1_idx_ff;

   logic [7:0] left_ff    [MAX_PIXEL_BYTES];
   logic [7:0] upleft_ff  [MAX_PIXEL_BYTES];

   logic       out_valid_ff;
   logic [7:0] out_pixel_ff;
   logic       out_row_end_ff;

   logic [7:0] a, b, c, x;
   logic [8:0] avg_sum;
   logic       out_free, adv;

   assign a       = left_ff[s1_idx_ff];
   assign c       = upleft_ff[s1_idx_ff];
   assign b       = s1_item_ff.first_row ? 8'd0 : up_byte;
   assign avg_sum = {1'b0, a} + {1'b0, b};

   always_comb begin
      unique case (s1_item_ff.filter)
         pngu_pkg::FILTER_SUB:   x = s1_item_ff.data + a;
         pngu_pkg::FILTER_UP:    x = s1_item_ff.data + b;
         pngu_pkg::FILTER_AVG:   x = s1_item_ff.data + avg_sum[8:1];
         pngu_pkg::FILTER_PAETH: x = s1_item_ff.data + paeth_pick(a, b, c);
         default:                x = s1_item_ff.data;
      endcase
   end

   // filter bytes leave without a result, so they never wait on the output
   assign out_free = !out_valid_ff || out_ready;
   assign adv      = s1_valid_ff && (!s1_item_ff.is_data || out_free);
   assign in_ready = !s1_valid_ff || adv;

   assign wr_en   = adv && s1_item_ff.is_data;
   assign wr_addr = s1_col_ff;
   assign wr_data = x;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= item;
         s1_col_ff  <= col;
         s1_idx_ff  <= hist_idx;
      end
      if (wr_en) begin
         out_pixel_ff   <= x;
         out_row_end_ff <= s1_item_ff.row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            left_ff[k]   <= 8'd0;
            upleft_ff[k] <= 8'd0;
         end
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (adv) begin
            if (s1_item_ff.is_data) begin
               for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
                  left_ff[k]   <= left_ff[k-1];
                  upleft_ff[k] <= upleft_ff[k-1];
               end
               left_ff[0]   <= x;
               upleft_ff[0] <= b;
            end else begin
               for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
                  left_ff[k]   <= 8'd0;
                  upleft_ff[k] <= 8'd0;
               end
            end
         end
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_pixel   = out_pixel_ff;
   assign out_row_end = out_row_end_ff;

endmodule

// File: src/png_scanline_unfilter_top.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top
// PNG scanline reconstruction (None, Sub, Up, Average, Paeth), one byte a cycle while results are taken.
// ----------------------------------------------------------------------------
// Throughput: one stream byte per cycle, filter bytes included, while results
//   are taken; a data byte and its row memory read are registered together,
//   then its result; a result held by the receiver stalls the next data byte.
// The left-neighbor loop (history, filter add, history) holds no other register.
// Reset is synchronous: control and histories clear at once, the row memory
//   is not cleared; the first row of each image reads zero as its up neighbor.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top #(
   parameter int MAX_ROW_BYTES   = 8192,
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   pngu_req_if.sink                        req_ch,
   pngu_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [pngu_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W      = $clog2(MAX_ROW_BYTES);
   localparam int HIST_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   pngu_pkg::pngu_item_type item;
   logic [COL_W-1:0]        col, wr_addr;
   logic [HIST_IDX_W-1:0]   hist_idx;
   logic [7:0]              up_byte, wr_data;
   logic                    in_ready, accept, wr_en;

   assign req_ch.ready = in_ready;
   assign accept       = req_ch.valid && in_ready;

   pngu_seq #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .start_image (req_ch.start_image),
      .stream_byte (req_ch.stream_byte),
      .item        (item),
      .col         (col),
      .hist_idx    (hist_idx)
   );

   // consecutive data bytes never share a column, so read and write never collide
   pngu_row_mem #(
      .DEPTH (MAX_ROW_BYTES)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept && item.is_data),
      .rd_addr (col),
      .rd_data (up_byte)
   );

   pngu_recon #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_recon (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .item        (item),
      .col         (col),
      .hist_idx    (hist_idx),
      .up_byte     (up_byte),
      .in_ready    (in_ready),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .out_pixel   (rsp_ch.pixel_byte),
      .out_row_end (rsp_ch.row_end)
   );

endmodule
